// ===== src/hcbd_pkg.sv =====
package hcbd_pkg;

    localparam int COUNT_BITS  = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_LEN_CAP     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STREAM_MODE = 1'b1;

    localparam logic [31:0] LEN_CAP_RST = 32'd1048576;

    localparam logic [7:0] CHAR_CR = 8'h0d;
    localparam logic [7:0] CHAR_LF = 8'h0a;

    localparam logic [1:0] SKIP_BYTES = 2'd2;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       start_body;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  data_out;
        logic        data_valid;
        logic        body_done;
        logic        truncated;
        logic        size_error;
        logic [31:0] body_length;
    } t_out_item;

    // classified byte handed from front to back
    typedef struct packed {
        logic [7:0] byte_in;
        logic       start_body;
        logic       is_hex;
        logic [3:0] hex_val;
        logic       is_cr;
        logic       is_lf;
    } t_cls_item;

    typedef enum logic [1:0] {
        PH_SIZE,
        PH_DATA,
        PH_SKIP,
        PH_DONE
    } t_phase;

endpackage

// ===== src/http_chunked_body_decoder.sv =====
// Chunked HTTP/1.1 body decoder, one raw body byte per item.
// Input channel: drive i_item and raise push; the item is taken at a clock
// edge where push is high and full is low. Set start_body on the first byte
// of each body to clear the parser state.
// Result channel: one result item per input item, in order. It is shown on
// o_result while empty is low and is taken at an edge where pop is high.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 = buffered length limit, 1 = stream mode); write only while idle.
// Path: an item is registered in the classify queue, parsed combinationally
// by the back end and registered again in the result queue before it is shown.
// Throughput: one item per cycle while results are popped, set by the parser step
// in the back end; a non-full queue moves an item in and out in the same cycle.
// Receiver stall: the result queue fills, the back end holds, the classify
// queue fills and full rises; nothing is dropped.
// Reset (synchronous, active low) empties both queues, clears the parser and
// restores the length limit to 1048576 and stream mode to 0.
module http_chunked_body_decoder #(
    parameter int COUNT_BITS  = hcbd_pkg::COUNT_BITS,
    parameter int QUEUE_DEPTH = hcbd_pkg::QUEUE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  hcbd_pkg::t_in_item               i_item,
    output logic                             empty,
    input  logic                             pop,
    output hcbd_pkg::t_out_item              o_result,
    input  logic                             i_cfg_we,
    input  logic [hcbd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [hcbd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int CLS_W = $bits(hcbd_pkg::t_cls_item);
    localparam int RES_W = $bits(hcbd_pkg::t_out_item);

    hcbd_pkg::t_cls_item cls_in;
    hcbd_pkg::t_cls_item cls_out;
    hcbd_pkg::t_out_item res;

    logic [CLS_W-1:0] cls_q;
    logic [RES_W-1:0] res_q;
    logic             cls_empty;
    logic             res_full;
    logic             fire;

    hcbd_front u_front (
        .i_item (i_item),
        .o_cls  (cls_in)
    );

    hcbd_queue #(
        .WIDTH (CLS_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_cls_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cls_in),
        .o_full  (full),
        .i_pop   (fire),
        .o_data  (cls_q),
        .o_empty (cls_empty)
    );

    assign cls_out = cls_q;
    assign fire    = !cls_empty && !res_full;

    hcbd_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_cls      (cls_out),
        .o_res      (res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    hcbd_queue #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_q),
        .o_empty (empty)
    );

    assign o_result = res_q;

endmodule

// ===== src/hcbd_queue.sv =====
module hcbd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = hcbd_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== src/hcbd_front.sv =====
module hcbd_front (
    input  hcbd_pkg::t_in_item  i_item,
    output hcbd_pkg::t_cls_item o_cls
);

    logic [7:0] b;
    logic       is_dec;
    logic       is_lower;
    logic       is_upper;
    logic [7:0] val;

    assign b        = i_item.byte_in;
    assign is_dec   = (b >= 8'h30) && (b <= 8'h39);
    assign is_lower = (b >= 8'h61) && (b <= 8'h66);
    assign is_upper = (b >= 8'h41) && (b <= 8'h46);

    always_comb begin
        val = 8'h00;
        if (is_dec) begin
            val = b - 8'h30;
        end else if (is_lower) begin
            val = b - 8'h57;
        end else if (is_upper) begin
            val = b - 8'h37;
        end
    end

    always_comb begin
        o_cls.byte_in    = b;
        o_cls.start_body = i_item.start_body;
        o_cls.is_hex     = is_dec || is_lower || is_upper;
        o_cls.hex_val    = val[3:0];
        o_cls.is_cr      = (b == hcbd_pkg::CHAR_CR);
        o_cls.is_lf      = (b == hcbd_pkg::CHAR_LF);
    end

endmodule

// ===== src/hcbd_back.sv =====
module hcbd_back #(
    parameter int COUNT_BITS = hcbd_pkg::COUNT_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_fire,
    input  hcbd_pkg::t_cls_item                 i_cls,
    output hcbd_pkg::t_out_item                 o_res,
    input  logic                                i_cfg_we,
    input  logic [hcbd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [hcbd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic [31:0] r_len_cap;
    logic        r_stream_mode;

    hcbd_pkg::t_phase      r_phase, n_phase, c_phase;
    logic [COUNT_BITS-1:0] r_chunk_left, n_chunk_left, c_chunk_left;
    logic [1:0]            r_skip, n_skip, c_skip;
    logic [31:0]           r_body_count, n_body_count, c_body_count;
    logic [COUNT_BITS-1:0] r_partial, n_partial, c_partial;
    logic                  r_prev_cr, n_prev_cr, c_prev_cr;
    logic                  r_past, n_past, c_past;

    logic                  crlf_end;
    logic                  size_ovf;
    logic                  limit_hit;
    logic [COUNT_BITS-1:0] chunk_dec;
    logic [1:0]            skip_dec;

    // start_body clears the body state before the byte is handled
    always_comb begin
        if (i_cls.start_body) begin
            c_phase      = hcbd_pkg::PH_SIZE;
            c_chunk_left = '0;
            c_skip       = '0;
            c_body_count = '0;
            c_partial    = '0;
            c_prev_cr    = 1'b0;
            c_past       = 1'b0;
        end else begin
            c_phase      = r_phase;
            c_chunk_left = r_chunk_left;
            c_skip       = r_skip;
            c_body_count = r_body_count;
            c_partial    = r_partial;
            c_prev_cr    = r_prev_cr;
            c_past       = r_past;
        end
    end

    assign crlf_end  = i_cls.is_lf && c_prev_cr;
    assign size_ovf  = |c_partial[COUNT_BITS-1:COUNT_BITS-4];
    assign limit_hit = !r_stream_mode && (c_body_count >= r_len_cap);
    assign chunk_dec = c_chunk_left - 1'b1;
    assign skip_dec  = c_skip - 1'b1;

    always_comb begin
        n_phase      = c_phase;
        n_chunk_left = c_chunk_left;
        n_skip       = c_skip;
        n_body_count = c_body_count;
        n_partial    = c_partial;
        n_prev_cr    = c_prev_cr;
        n_past       = c_past;
        case (c_phase)
            hcbd_pkg::PH_SIZE: begin
                if (crlf_end) begin
                    if (c_partial == '0) begin
                        n_phase = hcbd_pkg::PH_DONE;
                    end else begin
                        n_chunk_left = c_partial;
                        n_phase      = hcbd_pkg::PH_DATA;
                    end
                    n_partial = '0;
                    n_prev_cr = 1'b0;
                    n_past    = 1'b0;
                end else begin
                    n_prev_cr = i_cls.is_cr;
                    if (!i_cls.is_hex) begin
                        n_past = 1'b1;
                    end else if (!c_past) begin
                        if (size_ovf) begin
                            n_phase = hcbd_pkg::PH_DONE;
                        end else begin
                            n_partial = {c_partial[COUNT_BITS-5:0], i_cls.hex_val};
                        end
                    end
                end
            end
            hcbd_pkg::PH_DATA: begin
                if (limit_hit) begin
                    n_phase = hcbd_pkg::PH_DONE;
                end else begin
                    n_body_count = c_body_count + 1'b1;
                    n_chunk_left = chunk_dec;
                    if (chunk_dec == '0) begin
                        n_skip  = hcbd_pkg::SKIP_BYTES;
                        n_phase = hcbd_pkg::PH_SKIP;
                    end
                end
            end
            hcbd_pkg::PH_SKIP: begin
                n_skip = skip_dec;
                if (skip_dec == '0) begin
                    n_phase   = hcbd_pkg::PH_SIZE;
                    n_partial = '0;
                    n_prev_cr = 1'b0;
                    n_past    = 1'b0;
                end
            end
            default: begin
                n_phase = hcbd_pkg::PH_DONE;
            end
        endcase
    end

    always_comb begin
        o_res             = '0;
        o_res.body_length = n_body_count;
        case (c_phase)
            hcbd_pkg::PH_SIZE: begin
                if (crlf_end) begin
                    o_res.body_done = (c_partial == '0);
                end else if (i_cls.is_hex && !c_past && size_ovf) begin
                    o_res.body_done  = 1'b1;
                    o_res.size_error = 1'b1;
                end
            end
            hcbd_pkg::PH_DATA: begin
                if (limit_hit) begin
                    o_res.body_done = 1'b1;
                    o_res.truncated = 1'b1;
                end else begin
                    o_res.data_out   = i_cls.byte_in;
                    o_res.data_valid = 1'b1;
                end
            end
            default: begin
                o_res.body_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= hcbd_pkg::PH_SIZE;
            r_chunk_left <= '0;
            r_skip       <= '0;
            r_body_count <= '0;
            r_partial    <= '0;
            r_prev_cr    <= 1'b0;
            r_past       <= 1'b0;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_chunk_left <= n_chunk_left;
            r_skip       <= n_skip;
            r_body_count <= n_body_count;
            r_partial    <= n_partial;
            r_prev_cr    <= n_prev_cr;
            r_past       <= n_past;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_cap     <= hcbd_pkg::LEN_CAP_RST;
            r_stream_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                hcbd_pkg::CFG_LEN_CAP:     r_len_cap     <= i_cfg_data[31:0];
                hcbd_pkg::CFG_STREAM_MODE: r_stream_mode <= i_cfg_data[0];
                default: begin
                    r_stream_mode <= r_stream_mode;
                end
            endcase
        end
    end

endmodule

// ===== src/hcbd_checker.sv =====
module hcbd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                full,
    input logic                empty,
    input logic                pop,
    input hcbd_pkg::t_out_item o_result
);

    // reset leaves both queues empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result changed");

    // a payload byte never ends the body
    a_data_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !(o_result.data_valid && o_result.body_done))
        else $error("payload byte flagged as body end");

    a_flags_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_result.truncated || o_result.size_error)) |->
            (o_result.body_done && !(o_result.truncated && o_result.size_error)))
        else $error("error flag without body end");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);
